/* rtl/dls_pkg.sv */
// Package for the dense sigmoid layer: payload structs, register indexes,
// sizes, sigmoid table and controller/datapath command types. No dependencies.
package dls_pkg;

  localparam int MaxInputs  = 16;
  localparam int MaxOutputs = 16;
  localparam int WDepth     = MaxInputs * MaxOutputs;
  localparam int InW        = $clog2(MaxInputs);
  localparam int OutW       = $clog2(MaxOutputs);
  localparam int WAddrW     = $clog2(WDepth);
  localparam int AccW       = 38;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_BIAS   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam logic [1:0] REG_NUM_INPUTS  = 2'd0;
  localparam logic [1:0] REG_NUM_OUTPUTS = 2'd1;
  localparam logic [1:0] REG_DERIV_EN    = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  neuron;
    logic [15:0] activation;
    logic [13:0] derivative;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic            acc_init;
    logic            mac;
    logic            mac_last;
    logic [InW-1:0]  in_idx;
    logic [OutW-1:0] out_idx;
    logic            emit;
    logic            last;
  } dls_cmd_t;

  typedef struct packed {
    logic done;
  } dls_sts_t;

  function automatic logic [15:0] sig_tab(input logic [4:0] k);
    logic [15:0] t;
    case (k)
      5'd0:  t = 16'd16384;
      5'd1:  t = 16'd20397;
      5'd2:  t = 16'd23955;
      5'd3:  t = 16'd26790;
      5'd4:  t = 16'd28862;
      5'd5:  t = 16'd30282;
      5'd6:  t = 16'd31214;
      5'd7:  t = 16'd31807;
      5'd8:  t = 16'd32179;
      5'd9:  t = 16'd32408;
      5'd10: t = 16'd32549;
      5'd11: t = 16'd32635;
      5'd12: t = 16'd32687;
      5'd13: t = 16'd32719;
      5'd14: t = 16'd32738;
      5'd15: t = 16'd32750;
      default: t = 16'd32757;
    endcase
    return t;
  endfunction

endpackage

/* rtl/dls_ctrl.sv */
// Controller for the dense sigmoid layer: sequences bias load, MAC steps and
// result emission per output neuron. Depends on dls_pkg.
module dls_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [dls_pkg::InW:0]  ni,
  input  logic [dls_pkg::OutW:0] no,
  output dls_pkg::dls_cmd_t      cmd,
  input  dls_pkg::dls_sts_t      sts,
  output logic                   busy
);
  import dls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INIT = 4'b0010,
    S_MAC  = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [InW-1:0]  i_r, i_nxt;
  logic [OutW-1:0] o_r, o_nxt;
  logic [InW:0]    ni_r;
  logic [OutW:0]   no_r;
  logic            mac_end;

  assign mac_end = ({1'b0, i_r} == ni_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    o_nxt = o_r;
    cmd = '0;
    cmd.in_idx = i_r;
    cmd.out_idx = o_r;
    cmd.last = ({1'b0, o_r} == no_r - 1'b1);
    case (state_r)
      S_IDLE: begin
        o_nxt = '0;
        if (go) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.acc_init = 1'b1;
        i_nxt = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        cmd.mac_last = mac_end;
        i_nxt = i_r + 1'b1;
        if (mac_end) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.done) begin
          cmd.emit = 1'b1;
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else begin
            o_nxt = o_r + 1'b1;
            state_nxt = S_INIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0;
      o_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      o_r <= o_nxt;
    end
    if (state_r == S_IDLE && go) begin
      ni_r <= ni;
      no_r <= no;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> state_r == S_WAIT) else $error("emit outside wait");
  a_mac_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |=> state_r == S_MAC && i_r == '0) else $error("bad mac start");
  a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC && mac_end |=> state_r == S_WAIT) else $error("mac overrun");
endmodule

/* rtl/dls_datapath.sv */
// Datapath for the dense sigmoid layer: stores, shared MAC, rounding,
// sigmoid interpolation and derivative stages. Depends on dls_pkg.
module dls_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  dls_pkg::in_item_t     wr_item,
  input  logic                  deriv_en,
  input  dls_pkg::dls_cmd_t     cmd,
  output dls_pkg::dls_sts_t     sts,
  input  logic [dls_pkg::OutW:0] no,
  output logic                  out_valid,
  output dls_pkg::out_item_t    out_item
);
  import dls_pkg::*;

  logic [15:0] wmem [WDepth];
  logic [15:0] bias_r [MaxOutputs];
  logic [15:0] xvec_r [MaxInputs];

  logic signed [15:0] w_q_r, x_q_r, b_q_r;
  logic               mul_v_r, mul_last_r, init_d_r;
  logic signed [31:0] prod_r;
  logic               prod_v_r, prod_last_r;
  logic signed [AccW-1:0] acc_r;
  logic               acc_done_r;
  logic signed [15:0] r_r;
  logic               r_v_r;
  logic [15:0]        s_r;
  logic               s_v_r;
  logic [WAddrW-1:0]  waddr;
  logic [WAddrW+OutW:0] waddr_full;

  logic signed [AccW-1:0] sum_rnd;
  logic signed [AccW-13:0] sum_sh;
  logic signed [15:0] r_sat;
  logic               neg;
  logic [15:0]        mag;
  logic [4:0]         seg;
  logic [10:0]        frac;
  logic [15:0]        t0, t1;
  logic [27:0]        interp;
  logic [15:0]        s_pos, s_val;
  logic [31:0]        dprod;

  assign waddr_full = cmd.in_idx * no + cmd.out_idx;
  assign waddr = waddr_full[WAddrW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_item.kind)
        KIND_WEIGHT: wmem[wr_item.index[WAddrW-1:0]] <= wr_item.value;
        KIND_BIAS: if (wr_item.index < MaxOutputs)
          bias_r[wr_item.index[OutW-1:0]] <= wr_item.value;
        KIND_SAMPLE: if (wr_item.index < MaxInputs)
          xvec_r[wr_item.index[InW-1:0]] <= wr_item.value;
        default: ;
      endcase
    end
    w_q_r <= wmem[waddr];
    x_q_r <= xvec_r[cmd.in_idx];
    if (cmd.acc_init) b_q_r <= bias_r[cmd.out_idx];
    prod_r <= w_q_r * x_q_r;
  end

  always_comb begin
    sum_rnd = acc_r + AccW'(2048);
    sum_sh = sum_rnd[AccW-1:12];
    if (sum_sh > 32767) r_sat = 16'sd32767;
    else if (sum_sh < -32768) r_sat = -16'sd32768;
    else r_sat = sum_sh[15:0];
    neg = r_r[15];
    mag = neg ? 16'(-r_r) : r_r;
    seg = mag[15:11];
    frac = mag[10:0];
    t0 = sig_tab(seg);
    t1 = sig_tab(seg + 5'd1);
    interp = 28'(t1 - t0) * 28'(frac) + 28'd1024;
    s_pos = (seg >= 5'd16) ? t0 : 16'(t0 + interp[26:11]);
    s_val = neg ? 16'(17'd32768 - 17'(s_pos)) : s_pos;
    dprod = 32'(s_r) * 32'(17'd32768 - 17'(s_r)) + 32'd16384;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      mul_last_r <= 1'b0;
      init_d_r <= 1'b0;
      prod_v_r <= 1'b0;
      prod_last_r <= 1'b0;
      acc_done_r <= 1'b0;
      r_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      init_d_r <= cmd.acc_init;
      mul_v_r <= cmd.mac;
      mul_last_r <= cmd.mac & cmd.mac_last;
      prod_v_r <= mul_v_r;
      prod_last_r <= mul_last_r;
      acc_done_r <= prod_last_r;
      r_v_r <= acc_done_r;
      s_v_r <= r_v_r & ~cmd.emit;
    end
    if (init_d_r) acc_r <= AccW'(b_q_r) <<< 12;
    else if (prod_v_r) acc_r <= acc_r + AccW'(prod_r);
    r_r <= r_sat;
    if (r_v_r) s_r <= s_val;
    if (cmd.emit) begin
      out_item.neuron <= 4'(cmd.out_idx);
      out_item.activation <= s_r;
      out_item.derivative <= deriv_en ? dprod[28:15] : 14'd0;
      out_item.last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.emit;
  end

  assign sts.done = s_v_r;
endmodule

/* rtl/dense_layer_sigmoid_forward_core.sv */
// Dense layer with sigmoid: one result beat per output neuron after the last sample.
// The single shared MAC computes one output neuron at a time; busy is high while the
// layer computes, and loads are accepted only while busy is low. The receiver cannot
// stall. Synchronous active-low reset clears control and registers (16, 16, 0);
// stores are undefined until written. Depends on dls_*.
module dense_layer_sigmoid_forward_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dls_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output dls_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data
);
  import dls_pkg::*;

  logic [4:0] num_in_r, num_out_r;
  logic       deriv_r;
  logic [InW:0]  ni;
  logic [OutW:0] no;
  logic       acc, go;
  dls_cmd_t   cmd;
  dls_sts_t   sts;

  assign cfg_ready = 1'b1;
  assign ni = (num_in_r == 0) ? (InW+1)'(1) :
              (num_in_r > MaxInputs) ? (InW+1)'(MaxInputs) : (InW+1)'(num_in_r);
  assign no = (num_out_r == 0) ? (OutW+1)'(1) :
              (num_out_r > MaxOutputs) ? (OutW+1)'(MaxOutputs) : (OutW+1)'(num_out_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_in_r <= 5'd16;
      num_out_r <= 5'd16;
      deriv_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_INPUTS:  num_in_r <= cfg_data;
        REG_NUM_OUTPUTS: num_out_r <= cfg_data;
        REG_DERIV_EN:    deriv_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign acc = start && !busy;
  assign go = acc && in_item.kind == KIND_SAMPLE && in_item.index < MaxInputs &&
              {1'b0, in_item.index} == 9'(ni) - 9'd1;

  dls_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go(go), .ni(ni), .no(no),
    .cmd(cmd), .sts(sts), .busy(busy)
  );

  dls_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .wr_en(acc), .wr_item(in_item), .deriv_en(deriv_r),
    .cmd(cmd), .sts(sts), .no(no), .out_valid(out_strobe), .out_item(out_item)
  );
endmodule

/* dv/dense_layer_sigmoid_forward_core_test.sv */
// Self-checking testbench for dense_layer_sigmoid_forward_core: loads, samples and
// register writes are driven, and results are compared with a built-in layer predictor.
// Depends on dls_pkg and the block's RTL.
module dense_layer_sigmoid_forward_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dls_pkg::*;

  localparam int StallLimit = 5000;

  class layer_scoreboard;
    logic signed [15:0] weights [256];
    logic signed [15:0] biases [16];
    logic signed [15:0] samples [16];
    bit weight_set [256];
    bit bias_set [16];
    bit sample_set [16];
    logic [4:0] n_in_reg = 5'd16;
    logic [4:0] n_out_reg = 5'd16;
    bit deriv_on = 0;
    out_item_t pending_results [$];
    int errors = 0;
    int unsigned sig_points [17] = '{16384, 20397, 23955, 26790, 28862, 30282, 31214,
      31807, 32179, 32408, 32549, 32635, 32687, 32719, 32738, 32750, 32757};

    function int eff_inputs();
      return (n_in_reg < 1) ? 1 : (n_in_reg > 16) ? 16 : int'(n_in_reg);
    endfunction

    function int eff_outputs();
      return (n_out_reg < 1) ? 1 : (n_out_reg > 16) ? 16 : int'(n_out_reg);
    endfunction

    function int unsigned sigmoid_of(longint x);
      int unsigned a, seg, frac, s;
      a = (x < 0) ? int'(-x) : int'(x);
      seg = a >> 11;
      frac = a & 2047;
      if (seg >= 16) s = sig_points[16];
      else s = sig_points[seg] + (((sig_points[seg+1] - sig_points[seg]) * frac + 1024) >> 11);
      return (x < 0) ? 32768 - s : s;
    endfunction

    function void forward_pass();
      int ni, no;
      longint acc, r;
      int unsigned s, d;
      out_item_t e;
      ni = eff_inputs();
      no = eff_outputs();
      for (int o = 0; o < no; o++) begin
        acc = longint'(biases[o]) * 4096;
        for (int i = 0; i < ni; i++) acc += longint'(samples[i]) * longint'(weights[i*no+o]);
        r = (acc + 2048) >>> 12;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        s = sigmoid_of(r);
        d = deriv_on ? (s * (32768 - s) + 16384) >> 15 : 0;
        e.neuron = o[3:0];
        e.activation = s[15:0];
        e.derivative = d[13:0];
        e.last = (o == no - 1);
        pending_results.push_back(e);
      end
    endfunction

    function void note_input(in_item_t it);
      case (kind_t'(it.kind))
        KIND_WEIGHT: begin
          weights[it.index] = it.value;
          weight_set[it.index] = 1;
        end
        KIND_BIAS: if (it.index < 16) begin
          biases[it.index] = it.value;
          bias_set[it.index] = 1;
        end
        KIND_SAMPLE: if (it.index < 16) begin
          samples[it.index] = it.value;
          sample_set[it.index] = 1;
          if (it.index == eff_inputs() - 1) forward_pass();
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.neuron !== want.neuron) begin
        $display("%0t: neuron expected %0d actual %0d", $realtime, want.neuron, got.neuron);
        errors++;
      end
      if (got.activation !== want.activation) begin
        $display("%0t: activation expected %0d actual %0d", $realtime,
                 want.activation, got.activation);
        errors++;
      end
      if (got.derivative !== want.derivative) begin
        $display("%0t: derivative expected %0d actual %0d", $realtime,
                 want.derivative, got.derivative);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $realtime, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  int stall_cycles;
  layer_scoreboard sb;

  dense_layer_sigmoid_forward_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 2047)) - 16'd1024;
      3: return 16'($urandom_range(0, 16383)) - 16'd8192;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(logic [1:0] kind, logic [7:0] idx, logic [15:0] val);
    int gap;
    in_item_t it;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    it.kind = kind;
    it.index = idx;
    it.value = val;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  task automatic fill_missing();
    int ni, no;
    ni = sb.eff_inputs();
    no = sb.eff_outputs();
    for (int o = 0; o < no; o++)
      if (!sb.bias_set[o]) send_beat(KIND_BIAS, 8'(o), pick_value());
    for (int i = 0; i < ni; i++)
      for (int o = 0; o < no; o++)
        if (!sb.weight_set[i*no+o]) send_beat(KIND_WEIGHT, 8'(i*no+o), pick_value());
    for (int i = 0; i < ni - 1; i++)
      if (!sb.sample_set[i]) send_beat(KIND_SAMPLE, 8'(i), pick_value());
  endtask

  task automatic trigger(logic [15:0] val);
    fill_missing();
    send_beat(KIND_SAMPLE, 8'(sb.eff_inputs() - 1), val);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
    case (idx)
      REG_NUM_INPUTS: sb.n_in_reg = data;
      REG_NUM_OUTPUTS: sb.n_out_reg = data;
      REG_DERIV_EN: sb.deriv_on = data[0];
      default: ;
    endcase
  endtask

  task automatic set_layer(logic [4:0] ni, logic [4:0] no, logic de);
    drain();
    write_reg(REG_NUM_INPUTS, ni);
    write_reg(REG_NUM_OUTPUTS, no);
    write_reg(REG_DERIV_EN, {4'd0, de});
  endtask

  task automatic random_phase(int beats);
    int sent;
    int ni, no;
    sent = 0;
    ni = sb.eff_inputs();
    no = sb.eff_outputs();
    while (sent < beats) begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 9))
          0: send_beat(KIND_NONE, 8'($urandom), 16'($urandom));
          1: send_beat(KIND_BIAS, 8'($urandom_range(16, 255)), 16'($urandom));
          2: send_beat(KIND_SAMPLE, 8'($urandom_range(16, 255)), 16'($urandom));
          3: send_beat(KIND_WEIGHT, 8'($urandom), pick_value());
          4, 5: send_beat(KIND_BIAS, 8'($urandom_range(0, no - 1)), pick_value());
          default: send_beat(KIND_WEIGHT, 8'($urandom_range(0, ni * no - 1)), pick_value());
        endcase
        sent++;
      end
      for (int i = 0; i < ni - 1; i++)
        if ($urandom_range(0, 3) != 0) begin
          send_beat(KIND_SAMPLE, 8'(i), pick_value());
          sent++;
        end
      trigger(pick_value());
      sent++;
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 0;
    start <= 0;
    in_item <= '0;
    cfg_valid <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_layer(5'd2, 5'd3, 1'b1);
    send_beat(KIND_NONE, 8'hff, 16'hffff);
    send_beat(KIND_BIAS, 8'd16, 16'h1234);
    send_beat(KIND_SAMPLE, 8'd255, 16'h4321);
    for (int k = 0; k < 6; k++) send_beat(KIND_WEIGHT, 8'(k), 16'h7fff);
    for (int o = 0; o < 3; o++) send_beat(KIND_BIAS, 8'(o), 16'h7fff);
    send_beat(KIND_SAMPLE, 8'd0, 16'h7fff);
    send_beat(KIND_SAMPLE, 8'd1, 16'h7fff);
    send_beat(KIND_SAMPLE, 8'd0, 16'h8000);
    send_beat(KIND_SAMPLE, 8'd1, 16'h8000);
    for (int o = 0; o < 3; o++) send_beat(KIND_BIAS, 8'(o), 16'h8000);
    send_beat(KIND_SAMPLE, 8'd0, 16'h0000);
    send_beat(KIND_SAMPLE, 8'd1, 16'h0000);
    send_beat(KIND_WEIGHT, 8'd255, 16'h5555);
    set_layer(5'd1, 5'd1, 1'b0);
    send_beat(KIND_BIAS, 8'd0, 16'h0000);
    trigger(16'h0800);

    set_layer(5'd16, 5'd16, 1'b1);
    random_phase(30);
    set_layer(5'd0, 5'd31, 1'b0);
    random_phase(10);
    set_layer(5'd31, 5'd0, 1'b1);
    random_phase(15);
    set_layer(5'd1, 5'd16, 1'b1);
    random_phase(10);
    set_layer(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)), 1'($urandom));
    random_phase(10);
    set_layer(5'($urandom_range(1, 6)), 5'($urandom_range(1, 6)), 1'($urandom));
    random_phase(10);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
